### hdl/dda_pkg.sv
// shared types and constants for the dda line rasterizer
// depends on nothing; imported by every module of the block but dda_fifo
package dda_pkg;

    // command codes on the input channel
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_HEIGHT = 1'd1;

    // widths fixed by the screen interface
    localparam int unsigned CFG_BITS    = 11;
    localparam int unsigned OUT_BITS    = 13;
    localparam int unsigned STATUS_BITS = 2;

    // reset values of the origin registers
    localparam logic [CFG_BITS-1:0] HALF_WIDTH_RST  = 11'd320;
    localparam logic [CFG_BITS-1:0] HALF_HEIGHT_RST = 11'd240;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_PIXEL     = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_REJECT    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_IDLE_STEP = 2'd2;

    // kind of work queued between front and back
    typedef enum logic [1:0] {
        K_STEP,
        K_LOAD,
        K_REJECT
    } t_kind;

endpackage

### hdl/dda_fifo.sv
// small flip-flop queue between the front and back of the rasterizer
// generic in width and depth; no package dependency
module dda_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hdl/dda_front.sv
// front end: accepts requests, checks endpoint order, picks the major axis
// and forms the slope with a bit-serial divider; uses dda_pkg
module dda_front #(
    parameter int unsigned COORD_BITS = 11,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_cmd,
    input  logic signed [COORD_BITS-1:0] i_x_start,
    input  logic signed [COORD_BITS-1:0] i_y_start,
    input  logic signed [COORD_BITS-1:0] i_x_end,
    input  logic signed [COORD_BITS-1:0] i_y_end,
    input  logic                         i_full,
    output logic                         o_push,
    output dda_pkg::t_kind               o_kind,
    output logic                         o_x_major,
    output logic [COORD_BITS-1:0]        o_major_pos,
    output logic [COORD_BITS-1:0]        o_major_end,
    output logic [COORD_BITS-1:0]        o_minor_start,
    output logic [FRAC_BITS:0]           o_minor_step
);
    import dda_pkg::*;

    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned NW = $clog2(F + 1);
    localparam logic [NW-1:0] DIV_STEPS = NW'(F);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUSH
    } t_state;

    t_state       r_state, n_state;
    logic [C-1:0] r_rem, n_rem;
    logic [C-1:0] r_den, n_den;
    logic         r_q0, n_q0;
    logic [F-1:0] r_frac, n_frac;
    logic [NW-1:0] r_cnt, n_cnt;
    logic         r_x_major, n_x_major;
    logic [C-1:0] r_major_pos, n_major_pos;
    logic [C-1:0] r_major_end, n_major_end;
    logic [C-1:0] r_minor_start, n_minor_start;

    logic         accept;
    logic signed [C:0] dx_w, dy_w;
    logic         bad;
    logic [C-1:0] dx, dy, num, den;
    logic         xm;
    logic [C:0]   sh, diff;
    logic         ge;

    assign o_stall = (r_state != S_IDLE) || i_full;
    assign accept  = i_valid && !o_stall;

    // endpoint differences and ordering check
    assign dx_w = {i_x_end[C-1], i_x_end} - {i_x_start[C-1], i_x_start};
    assign dy_w = {i_y_end[C-1], i_y_end} - {i_y_start[C-1], i_y_start};
    assign bad  = dx_w[C] || dy_w[C];
    assign dx   = dx_w[C-1:0];
    assign dy   = dy_w[C-1:0];
    assign xm   = (dy < dx);
    assign num  = xm ? dy : dx;
    assign den  = xm ? dx : dy;

    // one restoring divide step per cycle
    assign sh   = {r_rem, 1'b0};
    assign diff = sh - {1'b0, r_den};
    assign ge   = (sh >= {1'b0, r_den});

    // queue write
    always_comb begin
        o_push = 1'b0;
        o_kind = K_LOAD;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd == CMD_STEP)) begin
                    o_push = 1'b1;
                    o_kind = K_STEP;
                end else if (accept && bad) begin
                    o_push = 1'b1;
                    o_kind = K_REJECT;
                end
            end
            S_PUSH: begin
                o_push = !i_full;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    assign o_x_major     = r_x_major;
    assign o_major_pos   = r_major_pos;
    assign o_major_end   = r_major_end;
    assign o_minor_start = r_minor_start;
    assign o_minor_step  = {r_q0, r_frac};

    // next-state logic
    always_comb begin
        n_state       = r_state;
        n_rem         = r_rem;
        n_den         = r_den;
        n_q0          = r_q0;
        n_frac        = r_frac;
        n_cnt         = r_cnt;
        n_x_major     = r_x_major;
        n_major_pos   = r_major_pos;
        n_major_end   = r_major_end;
        n_minor_start = r_minor_start;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd == CMD_LOAD) && !bad) begin
                    n_x_major     = xm;
                    n_major_pos   = xm ? i_x_start : i_y_start;
                    n_major_end   = xm ? i_x_end : i_y_end;
                    n_minor_start = xm ? i_y_start : i_x_start;
                    n_den         = den;
                    n_frac        = '0;
                    n_cnt         = DIV_STEPS;
                    if (den == '0) begin
                        // zero-length line steps by nothing
                        n_q0    = 1'b0;
                        n_state = S_PUSH;
                    end else begin
                        n_q0    = (num == den);
                        n_rem   = (num == den) ? '0 : num;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem  = ge ? diff[C-1:0] : sh[C-1:0];
                n_frac = {r_frac[F-2:0], ge};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == NW'(1)) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and divider registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_rem         <= n_rem;
        r_den         <= n_den;
        r_q0          <= n_q0;
        r_frac        <= n_frac;
        r_cnt         <= n_cnt;
        r_x_major     <= n_x_major;
        r_major_pos   <= n_major_pos;
        r_major_end   <= n_major_end;
        r_minor_start <= n_minor_start;
    end

endmodule

### hdl/dda_back.sv
// back end: holds the active line, steps the accumulator and registers
// one result per step or rejected load; uses dda_pkg
module dda_back #(
    parameter int unsigned COORD_BITS = 11,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_q_valid,
    input  dda_pkg::t_kind                             i_q_kind,
    input  logic                                       i_q_x_major,
    input  logic [COORD_BITS-1:0]                      i_q_major_pos,
    input  logic [COORD_BITS-1:0]                      i_q_major_end,
    input  logic [COORD_BITS-1:0]                      i_q_minor_start,
    input  logic [FRAC_BITS:0]                         i_q_minor_step,
    output logic                                       o_q_pop,
    input  logic [dda_pkg::CFG_BITS-1:0]               i_half_width,
    input  logic [dda_pkg::CFG_BITS-1:0]               i_half_height,
    output logic                                       o_valid,
    input  logic                                       i_stall,
    output logic signed [dda_pkg::OUT_BITS-1:0]        o_pixel_col,
    output logic signed [dda_pkg::OUT_BITS-1:0]        o_pixel_row,
    output logic                                       o_last,
    output logic [dda_pkg::STATUS_BITS-1:0]            o_status
);
    import dda_pkg::*;

    localparam int unsigned C     = COORD_BITS;
    localparam int unsigned F     = FRAC_BITS;
    localparam int unsigned AW    = C + F + 1;
    localparam int unsigned SUM_W = C + CFG_BITS + 2;
    localparam logic [AW-1:0] HALF_LSB = AW'(1) << (F - 1);

    logic                 r_active, n_active;
    logic                 r_x_major, n_x_major;
    logic signed [C-1:0]  r_major_pos, n_major_pos;
    logic signed [C-1:0]  r_major_end, n_major_end;
    logic [AW-1:0]        r_acc, n_acc;
    logic [F:0]           r_step, n_step;

    logic                 r_out_valid, n_out_valid;
    logic [OUT_BITS-1:0]  r_col, n_col;
    logic [OUT_BITS-1:0]  r_row, n_row;
    logic                 r_last, n_last;
    logic [STATUS_BITS-1:0] r_status, n_status;

    logic                 can_out;
    logic [AW-1:0]        acc_rnd;
    logic signed [C:0]    minor;
    logic signed [C:0]    x_sel, y_sel;
    logic signed [SUM_W-1:0] col_w, row_w;
    logic                 fin;

    assign can_out = !r_out_valid || !i_stall;

    // pixel position from the current state
    assign acc_rnd = r_acc + HALF_LSB;
    assign minor   = acc_rnd[AW-1:F];
    assign x_sel   = r_x_major ? {r_major_pos[C-1], r_major_pos} : minor;
    assign y_sel   = r_x_major ? minor : {r_major_pos[C-1], r_major_pos};
    assign col_w   = $signed({{(SUM_W-CFG_BITS){1'b0}}, i_half_width}) + SUM_W'(x_sel);
    assign row_w   = $signed({{(SUM_W-CFG_BITS){1'b0}}, i_half_height}) - SUM_W'(y_sel);
    assign fin     = (r_major_pos >= r_major_end);

    // queue pop and line state update
    always_comb begin
        n_active    = r_active;
        n_x_major   = r_x_major;
        n_major_pos = r_major_pos;
        n_major_end = r_major_end;
        n_acc       = r_acc;
        n_step      = r_step;
        n_out_valid = r_out_valid && i_stall;
        n_col       = r_col;
        n_row       = r_row;
        n_last      = r_last;
        n_status    = r_status;
        o_q_pop     = 1'b0;
        if (i_q_valid) begin
            case (i_q_kind)
                K_LOAD: begin
                    o_q_pop     = 1'b1;
                    n_active    = 1'b1;
                    n_x_major   = i_q_x_major;
                    n_major_pos = i_q_major_pos;
                    n_major_end = i_q_major_end;
                    n_acc       = {i_q_minor_start[C-1], i_q_minor_start, {F{1'b0}}};
                    n_step      = i_q_minor_step;
                end
                K_REJECT: begin
                    if (can_out) begin
                        o_q_pop     = 1'b1;
                        n_active    = 1'b0;
                        n_out_valid = 1'b1;
                        n_col       = '0;
                        n_row       = '0;
                        n_last      = 1'b0;
                        n_status    = ST_REJECT;
                    end
                end
                K_STEP: begin
                    if (can_out) begin
                        o_q_pop     = 1'b1;
                        n_out_valid = 1'b1;
                        if (!r_active) begin
                            n_col    = '0;
                            n_row    = '0;
                            n_last   = 1'b0;
                            n_status = ST_IDLE_STEP;
                        end else begin
                            n_col    = col_w[OUT_BITS-1:0];
                            n_row    = row_w[OUT_BITS-1:0];
                            n_last   = fin;
                            n_status = ST_PIXEL;
                            if (fin) begin
                                n_active = 1'b0;
                            end else begin
                                n_major_pos = r_major_pos + 1'b1;
                                n_acc       = r_acc + {{C{1'b0}}, r_step};
                            end
                        end
                    end
                end
                default: begin
                    o_q_pop = 1'b1;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    // line state and result payload
    always_ff @(posedge i_clk) begin
        r_x_major   <= n_x_major;
        r_major_pos <= n_major_pos;
        r_major_end <= n_major_end;
        r_acc       <= n_acc;
        r_step      <= n_step;
        r_col       <= n_col;
        r_row       <= n_row;
        r_last      <= n_last;
        r_status    <= n_status;
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_col = r_col;
    assign o_pixel_row = r_row;
    assign o_last      = r_last;
    assign o_status    = r_status;

endmodule

### hdl/dda_line_rasterizer_unit.sv
// DDA line rasterizer, top level.
// Input channel (i_valid / o_stall) carries a load request with two endpoints
// in center-origin coordinates, or a step request that emits the next pixel.
// Output channel (o_valid / i_stall) carries screen column and row, a last
// flag and a status code; every step and every rejected load gives one result.
// Step requests flow at one per cycle unless the front is busy or the queue is
// full; with an empty queue a pixel passes the queue write and output register.
// A load holds the front through divide and push, a zero-length line only push;
// the slope divider makes one quotient bit per cycle. Steps wait behind it.
// A four-entry queue decouples the front from the back, so a stalled receiver
// backs up into the queue before the input channel stalls.
// While i_stall is high the result stays put and o_valid holds.
// Synchronous reset clears the line state, empties the queue and restores
// the origin registers to column 320 and row 240.
// Origin registers are written through i_cfg_we / i_cfg_idx / i_cfg_data;
// the user writes them only while the block is idle, which it does not enforce.
// depends on dda_pkg, dda_front, dda_fifo and dda_back
module dda_line_rasterizer_unit #(
    parameter int unsigned COORD_BITS = 11,
    parameter int unsigned FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic signed [COORD_BITS-1:0]        i_x_start,
    input  logic signed [COORD_BITS-1:0]        i_y_start,
    input  logic signed [COORD_BITS-1:0]        i_x_end,
    input  logic signed [COORD_BITS-1:0]        i_y_end,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [dda_pkg::OUT_BITS-1:0] o_pixel_col,
    output logic signed [dda_pkg::OUT_BITS-1:0] o_pixel_row,
    output logic                                o_last,
    output logic [dda_pkg::STATUS_BITS-1:0]     o_status,
    input  logic                                i_cfg_we,
    input  logic [dda_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [dda_pkg::CFG_BITS-1:0]        i_cfg_data
);
    import dda_pkg::*;

    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned EW = 2 + 1 + 3 * C + F + 1;
    localparam int unsigned Q_DEPTH = 4;

    logic [CFG_BITS-1:0] r_half_width;
    logic [CFG_BITS-1:0] r_half_height;

    logic          push, full, pop, q_valid;
    t_kind         f_kind;
    logic          f_x_major;
    logic [C-1:0]  f_major_pos, f_major_end, f_minor_start;
    logic [F:0]    f_minor_step;
    logic [EW-1:0] push_data, q_data;

    // origin registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width  <= HALF_WIDTH_RST;
            r_half_height <= HALF_HEIGHT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_HALF_WIDTH) begin
                r_half_width <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_HALF_HEIGHT) begin
                r_half_height <= i_cfg_data;
            end
        end
    end

    // request classification and slope divider
    dda_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_full        (full),
        .o_push        (push),
        .o_kind        (f_kind),
        .o_x_major     (f_x_major),
        .o_major_pos   (f_major_pos),
        .o_major_end   (f_major_end),
        .o_minor_start (f_minor_start),
        .o_minor_step  (f_minor_step)
    );

    assign push_data = {f_kind, f_x_major, f_major_pos, f_major_end,
                        f_minor_start, f_minor_step};

    // work queue between front and back
    dda_fifo #(
        .WIDTH (EW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // line stepping and result register
    dda_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_kind        (t_kind'(q_data[EW-1 -: 2])),
        .i_q_x_major     (q_data[EW-3]),
        .i_q_major_pos   (q_data[3*C+F : 2*C+F+1]),
        .i_q_major_end   (q_data[2*C+F : C+F+1]),
        .i_q_minor_start (q_data[C+F : F+1]),
        .i_q_minor_step  (q_data[F:0]),
        .o_q_pop         (pop),
        .i_half_width    (r_half_width),
        .i_half_height   (r_half_height),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_col     (o_pixel_col),
        .o_pixel_row     (o_pixel_row),
        .o_last          (o_last),
        .o_status        (o_status)
    );

endmodule

### verif/dda_line_rasterizer_unit_tb.sv
// self-checking testbench for the dda line rasterizer top level
// drives load and step requests, predicts every pixel, reject and idle-step result
// depends on dda_pkg and dda_line_rasterizer_unit
module dda_line_rasterizer_unit_tb;
    import dda_pkg::*;

    localparam int COORD_BITS  = 11;
    localparam int FRAC_BITS   = 16;
    localparam int OUT_W       = OUT_BITS;
    localparam int PHASE_ITEMS = 270;
    localparam int SETTLE      = 48;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_LEN    = 80;
    localparam int DRAIN_AT    = 500;

    typedef struct {
        logic                         cmd;
        logic signed [COORD_BITS-1:0] x_start;
        logic signed [COORD_BITS-1:0] y_start;
        logic signed [COORD_BITS-1:0] x_end;
        logic signed [COORD_BITS-1:0] y_end;
    } t_line_req;

    typedef struct {
        logic [OUT_W-1:0]       col;
        logic [OUT_W-1:0]       row;
        logic                   last;
        logic [STATUS_BITS-1:0] status;
    } t_pixel;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_valid    = 1'b0;
    logic                          o_stall;
    logic                          i_cmd      = CMD_LOAD;
    logic signed [COORD_BITS-1:0]  i_x_start  = '0;
    logic signed [COORD_BITS-1:0]  i_y_start  = '0;
    logic signed [COORD_BITS-1:0]  i_x_end    = '0;
    logic signed [COORD_BITS-1:0]  i_y_end    = '0;
    logic                          o_valid;
    logic                          i_stall    = 1'b0;
    logic signed [OUT_W-1:0]       o_pixel_col;
    logic signed [OUT_W-1:0]       o_pixel_row;
    logic                          o_last;
    logic [STATUS_BITS-1:0]        o_status;
    logic                          i_cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]       i_cfg_idx  = CFG_HALF_WIDTH;
    logic [CFG_BITS-1:0]           i_cfg_data = '0;

    // request and result stores
    t_line_req reqs_to_send[$];
    t_pixel    pixels_due[$];
    t_line_req req_on_bus;

    // line state and origin as the block should hold them
    bit                 ln_active     = 1'b0;
    bit                 ln_x_major    = 1'b0;
    int                 ln_major_pos  = 0;
    int                 ln_major_end  = 0;
    longint             ln_minor_acc  = 0;
    longint unsigned    ln_minor_step = 0;
    logic [CFG_BITS-1:0] org_col      = HALF_WIDTH_RST;
    logic [CFG_BITS-1:0] org_row      = HALF_HEIGHT_RST;

    // run bookkeeping
    bit quiet         = 1'b0;
    bit sender_drain  = 1'b0;
    bit hold_done     = 1'b0;
    int hold_left     = 0;
    int idle_cycles   = 0;
    int n_reqs        = 0;
    int n_results     = 0;
    int n_errors      = 0;
    int n_rejects     = 0;
    int n_idle_steps  = 0;
    int n_line_ends   = 0;
    int n_settings    = 1;

    dda_line_rasterizer_unit #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd      (i_cmd),
        .i_x_start  (i_x_start),
        .i_y_start  (i_y_start),
        .i_x_end    (i_x_end),
        .i_y_end    (i_y_end),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_pixel_col(o_pixel_col),
        .o_pixel_row(o_pixel_row),
        .o_last     (o_last),
        .o_status   (o_status),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predicts the result of one request and advances the line state
    function automatic bit rasterize_request(input t_line_req r, output t_pixel px);
        int              xs;
        int              ys;
        int              xe;
        int              ye;
        int              minor;
        int              px_x;
        int              px_y;
        longint          rounded;
        longint unsigned dx;
        longint unsigned dy;
        bit              fin;
        px.col    = '0;
        px.row    = '0;
        px.last   = 1'b0;
        px.status = ST_PIXEL;
        if (r.cmd == CMD_LOAD) begin
            xs = r.x_start;
            ys = r.y_start;
            xe = r.x_end;
            ye = r.y_end;
            // endpoints out of order
            if (xe < xs || ye < ys) begin
                ln_active = 1'b0;
                px.status = ST_REJECT;
                n_rejects++;
                return 1'b1;
            end
            dx = longint'(xe - xs);
            dy = longint'(ye - ys);
            ln_x_major = dy < dx;
            if (ln_x_major) begin
                ln_major_pos  = xs;
                ln_major_end  = xe;
                ln_minor_acc  = longint'(ys) * (64'sd1 <<< FRAC_BITS);
                ln_minor_step = (dy << FRAC_BITS) / dx;
            end else begin
                ln_major_pos  = ys;
                ln_major_end  = ye;
                ln_minor_acc  = longint'(xs) * (64'sd1 <<< FRAC_BITS);
                ln_minor_step = (dy == 0) ? 64'd0 : (dx << FRAC_BITS) / dy;
            end
            ln_active = 1'b1;
            return 1'b0;
        end
        // step with no line in progress
        if (!ln_active) begin
            px.status = ST_IDLE_STEP;
            n_idle_steps++;
            return 1'b1;
        end
        // minor coordinate rounded half up
        rounded = ln_minor_acc + (64'sd1 <<< (FRAC_BITS - 1));
        minor   = int'(rounded >>> FRAC_BITS);
        px_x    = ln_x_major ? ln_major_pos : minor;
        px_y    = ln_x_major ? minor : ln_major_pos;
        fin     = ln_major_pos >= ln_major_end;
        px.col  = OUT_W'(int'(org_col) + px_x);
        px.row  = OUT_W'(int'(org_row) - px_y);
        px.last = fin;
        if (fin) begin
            ln_active = 1'b0;
            n_line_ends++;
        end else begin
            ln_major_pos++;
            ln_minor_acc += longint'(ln_minor_step);
        end
        return 1'b1;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_pixel px;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            // request taken by the block
            if (i_valid && !o_stall) begin
                if (rasterize_request(req_on_bus, px)) begin
                    pixels_due.push_back(px);
                end
                n_reqs++;
                if (n_reqs == DRAIN_AT) begin
                    sender_drain = 1'b1;
                end
            end
            if (sender_drain && pixels_due.size() == 0) begin
                sender_drain = 1'b0;
            end
            // offer the next request unless the current one is held
            if (!i_valid || !o_stall) begin
                if (reqs_to_send.size() != 0 && !sender_drain &&
                    !(!quiet && $urandom_range(99) < 11)) begin
                    req_on_bus = reqs_to_send.pop_front();
                    i_valid   <= 1'b1;
                    i_cmd     <= req_on_bus.cmd;
                    i_x_start <= req_on_bus.x_start;
                    i_y_start <= req_on_bus.y_start;
                    i_x_end   <= req_on_bus.x_end;
                    i_y_end   <= req_on_bus.y_end;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_results >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < 11);
        end
    end

    task automatic check_field(input string what, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, what,
                     $signed(want), $signed(got));
            n_errors++;
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pixels_due.size() == 0) begin
                $display("%0t: unexpected result expected none actual col %0d row %0d status %0d",
                         $time, o_pixel_col, o_pixel_row, o_status);
                n_errors++;
            end else begin
                want = pixels_due.pop_front();
                check_field("pixel_col", want.col, o_pixel_col);
                check_field("pixel_row", want.row, o_pixel_row);
                check_field("last", OUT_W'(want.last), OUT_W'(o_last));
                check_field("status", OUT_W'(want.status), OUT_W'(o_status));
            end
            n_results++;
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no traffic for %0d cycles, %0d results still due",
                     $time, idle_cycles, pixels_due.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_load(input int xs, input int ys, input int xe, input int ye);
        t_line_req r;
        r.cmd     = CMD_LOAD;
        r.x_start = COORD_BITS'(xs);
        r.y_start = COORD_BITS'(ys);
        r.x_end   = COORD_BITS'(xe);
        r.y_end   = COORD_BITS'(ye);
        reqs_to_send.push_back(r);
    endtask

    // step requests carry don't-care endpoints, randomized
    task automatic push_steps(input int n);
        t_line_req r;
        for (int k = 0; k < n; k++) begin
            r.cmd     = CMD_STEP;
            r.x_start = COORD_BITS'($urandom);
            r.y_start = COORD_BITS'($urandom);
            r.x_end   = COORD_BITS'($urandom);
            r.y_end   = COORD_BITS'($urandom);
            reqs_to_send.push_back(r);
        end
    endtask

    // start coordinate that leaves room for a span inside the signed range
    function automatic int start_for(input int span);
        return int'($urandom_range(2047 - span)) - 1024;
    endfunction

    task automatic queue_directed();
        push_steps(1);                              // step while idle
        push_load(0, 0, 0, 0);                      // zero-length line
        push_steps(2);
        push_load(-2, -2, 1, 1);                    // equal dx and dy, slope one
        push_steps(4);
        push_load(5, 0, 4, 0);                      // x out of order
        push_steps(1);
        push_load(0, 5, 0, 4);                      // y out of order
        push_load(-1024, -1024, 1023, 1023);        // full span, replaced early
        push_steps(2);
        push_load(-1024, 1023, 1023, 1023);         // flat x-major at the top edge
        push_steps(2);
        push_load(1023, 1023, 1023, 1023);          // zero-length at the far corner
        push_steps(1);
        push_load(-4, -3, 0, -1);                   // half-way minor values, negative
        push_steps(5);
    endtask

    // one well-formed line, mostly walked to its end
    task automatic queue_line();
        int dmaj;
        int dmin;
        int smaj;
        int smin;
        int pick;
        int nsteps;
        pick = $urandom_range(99);
        if (pick < 80) begin
            dmaj = $urandom_range(16);
        end else if (pick < 97) begin
            dmaj = $urandom_range(120, 17);
        end else begin
            dmaj = $urandom_range(400, 121);
        end
        dmin = ($urandom_range(99) < 15) ? dmaj : int'($urandom_range(dmaj));
        smaj = start_for(dmaj);
        smin = start_for(dmin);
        if ($urandom_range(1) == 1) begin
            push_load(smaj, smin, smaj + dmaj, smin + dmin);
        end else begin
            push_load(smin, smaj, smin + dmin, smaj + dmaj);
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
            nsteps = $urandom_range(dmaj);
        end else if (pick < 20) begin
            nsteps = dmaj + 1 + int'($urandom_range(2, 1));
        end else begin
            nsteps = dmaj + 1;
        end
        push_steps(nsteps);
    endtask

    // stray loads, out-of-order endpoints and lone steps
    task automatic queue_noise();
        int pick;
        int xs;
        int xe;
        pick = $urandom_range(99);
        if (pick < 50) begin
            push_load(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
        end else if (pick < 80) begin
            xs = int'($urandom_range(2046)) - 1023;
            xe = int'($urandom_range(xs + 1023)) - 1024;
            if ($urandom_range(1) == 1) begin
                push_load(xs, int'($urandom), xe, int'($urandom));
            end else begin
                push_load(int'($urandom_range(2047)) - 1024, xs,
                          int'($urandom_range(2047)) - 1024, xe);
            end
        end else begin
            push_steps(1);
        end
    endtask

    task automatic queue_random(input int budget);
        int target;
        target = reqs_to_send.size() + budget;
        while (reqs_to_send.size() < target) begin
            if ($urandom_range(99) < 82) begin
                queue_line();
            end else begin
                queue_noise();
            end
        end
    endtask

    // wait for every request and result, then for a load still in the divider
    task automatic drain_and_settle();
        @(negedge i_clk);
        while (reqs_to_send.size() != 0 || i_valid || pixels_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_origin(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HALF_WIDTH) begin
            org_col = val;
        end else begin
            org_row = val;
        end
    endtask

    task automatic run_phase(input logic [CFG_BITS-1:0] hw, input logic [CFG_BITS-1:0] hh,
                             input bit no_gaps);
        write_origin(CFG_HALF_WIDTH, hw);
        write_origin(CFG_HALF_HEIGHT, hh);
        n_settings++;
        @(negedge i_clk);
        quiet = no_gaps;
        queue_random(PHASE_ITEMS);
        drain_and_settle();
        quiet = 1'b0;
    endtask

    // stimulus sequence and verdict
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        queue_directed();
        queue_random(PHASE_ITEMS);
        drain_and_settle();
        run_phase(11'd0, 11'd0, 1'b0);
        run_phase(11'd2047, 11'd2047, 1'b0);
        run_phase(11'd2047, 11'd0, 1'b1);
        run_phase(CFG_BITS'($urandom_range(2047)), CFG_BITS'($urandom_range(2047)), 1'b0);
        $display("run: %0d requests, %0d results over %0d origin settings",
                 n_reqs, n_results, n_settings);
        $display("run: %0d rejected loads, %0d idle steps, %0d completed lines, %0d errors",
                 n_rejects, n_idle_steps, n_line_ends, n_errors);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
hdl/dda_pkg.sv
hdl/dda_fifo.sv
hdl/dda_front.sv
hdl/dda_back.sv
hdl/dda_line_rasterizer_unit.sv
verif/dda_line_rasterizer_unit_tb.sv
